// ----- design/fds16_pkg.sv -----
// ----------------------------------------------------------------------------
// fds16_pkg
// Shared types and constants for the 17-byte frame deframer.
// ----------------------------------------------------------------------------
package fds16_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PayLen   = 8;
  localparam int unsigned PayIdxW  = $clog2(PayLen);
  localparam int unsigned SumW     = 12;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned OutDataW = (PayLen + 2) * ByteW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HEAD1     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAD2     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_HEAD2_ALT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RX_ID     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TAIL1     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TAIL2     = 3'd5;

  // operations passed from the parser to the frame store
  typedef enum logic [1:0] {
    OP_FUNC    = 2'd0,
    OP_SUBFUNC = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_EMIT    = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [PayIdxW-1:0] idx;
    logic [ByteW-1:0]   data;
  } q_entry_t;

endpackage

// ----- design/frame_deframer_sum16.sv -----
// On its last trailer byte a frame is queued, then loaded into the output register.
// Throughput: one byte per cycle; the parser front end never stalls on its own.
// Input stalls only when a finished frame waits on the output and the
// two-entry operation queue behind it has filled.
// Reset: asynchronous, active low; parser to header hunt, control registers to zero.
// ----------------------------------------------------------------------------
// frame_deframer_sum16
// Receives bytes, recognizes 17-byte frames with a 12-bit additive checksum
// and emits the function code, sub-function code and eight payload bytes.
// ----------------------------------------------------------------------------
module frame_deframer_sum16 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fds16_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fds16_pkg::ByteW-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [fds16_pkg::ByteW-1:0]      s_axis_tdata,  // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // function_code, sub_function_code, payload0 .. payload7, 8 bits each
  output logic [fds16_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic                push, q_full, q_valid, q_pop, in_acc;
  fds16_pkg::q_entry_t push_entry, head_entry;

  assign s_axis_tready = !q_full;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  fds16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (in_acc),
    .byte_i     (s_axis_tdata),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  fds16_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .rdata_o (head_entry)
  );

  fds16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- design/fds16_front.sv -----
// ----------------------------------------------------------------------------
// fds16_front
// Byte parser: tracks frame phase, checks header/id/checksum/trailer bytes
// and issues store and emit operations toward the frame store.
// ----------------------------------------------------------------------------
module fds16_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fds16_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [fds16_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                            accept_i,
  input  logic [fds16_pkg::ByteW-1:0]     byte_i,
  output logic                            push_o,
  output fds16_pkg::q_entry_t             entry_o
);

  localparam logic [fds16_pkg::PhaseW-1:0] PH_HEAD1   = 4'd0;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_HEAD2   = 4'd1;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_ID      = 4'd2;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_FUNC    = 4'd3;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_SUBFUNC = 4'd4;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_PAYLOAD = 4'd5;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_CK_HI   = 4'd6;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_CK_LO   = 4'd7;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_TAIL1   = 4'd8;
  localparam logic [fds16_pkg::PhaseW-1:0] PH_TAIL2   = 4'd9;

  localparam logic [fds16_pkg::PayIdxW-1:0] LastIdx =
    fds16_pkg::PayIdxW'(fds16_pkg::PayLen - 1);

  logic [fds16_pkg::ByteW-1:0]   head1_q, head2_q, head2_alt_q, rx_id_q, tail1_q, tail2_q;
  logic [fds16_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [fds16_pkg::SumW-1:0]    sum_q, sum_d, sum_add;
  logic [fds16_pkg::ByteW-1:0]   ck_hi_q, ck_hi_d;
  logic [fds16_pkg::PayIdxW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head1_q     <= '0;
      head2_q     <= '0;
      head2_alt_q <= '0;
      rx_id_q     <= '0;
      tail1_q     <= '0;
      tail2_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fds16_pkg::CFG_HEAD1:     head1_q     <= cfg_data_i;
        fds16_pkg::CFG_HEAD2:     head2_q     <= cfg_data_i;
        fds16_pkg::CFG_HEAD2_ALT: head2_alt_q <= cfg_data_i;
        fds16_pkg::CFG_RX_ID:     rx_id_q     <= cfg_data_i;
        fds16_pkg::CFG_TAIL1:     tail1_q     <= cfg_data_i;
        fds16_pkg::CFG_TAIL2:     tail2_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sum_add = sum_q + fds16_pkg::SumW'(byte_i);

  always_comb begin
    phase_d       = phase_q;
    sum_d         = sum_q;
    ck_hi_d       = ck_hi_q;
    cnt_d         = cnt_q;
    push_o        = 1'b0;
    entry_o.op    = fds16_pkg::OP_FUNC;
    entry_o.idx   = cnt_q;
    entry_o.data  = byte_i;
    if (accept_i) begin
      unique case (phase_q)
        PH_HEAD1: phase_d = (byte_i == head1_q) ? PH_HEAD2 : PH_HEAD1;
        PH_HEAD2: phase_d = (byte_i == head2_q || byte_i == head2_alt_q) ? PH_ID : PH_HEAD1;
        PH_ID: begin
          if (byte_i == rx_id_q) begin
            sum_d   = fds16_pkg::SumW'(byte_i);
            phase_d = PH_FUNC;
          end else begin
            phase_d = PH_HEAD1;
          end
        end
        PH_FUNC: begin
          sum_d      = sum_add;
          push_o     = 1'b1;
          entry_o.op = fds16_pkg::OP_FUNC;
          phase_d    = PH_SUBFUNC;
        end
        PH_SUBFUNC: begin
          sum_d      = sum_add;
          push_o     = 1'b1;
          entry_o.op = fds16_pkg::OP_SUBFUNC;
          cnt_d      = '0;
          phase_d    = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_d      = sum_add;
          push_o     = 1'b1;
          entry_o.op = fds16_pkg::OP_PAYLOAD;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == LastIdx) begin
            phase_d = PH_CK_HI;
          end
        end
        PH_CK_HI: begin
          ck_hi_d = byte_i;
          phase_d = PH_CK_LO;
        end
        PH_CK_LO: begin
          phase_d = ({ck_hi_q, byte_i} == {4'd0, sum_q}) ? PH_TAIL1 : PH_HEAD1;
        end
        PH_TAIL1: phase_d = (byte_i == tail1_q) ? PH_TAIL2 : PH_HEAD1;
        PH_TAIL2: begin
          if (byte_i == tail2_q) begin
            push_o     = 1'b1;
            entry_o.op = fds16_pkg::OP_EMIT;
          end
          phase_d = PH_HEAD1;
        end
        default: phase_d = PH_HEAD1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD1;
      sum_q   <= '0;
      ck_hi_q <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      ck_hi_q <= ck_hi_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- design/fds16_queue.sv -----
// ----------------------------------------------------------------------------
// fds16_queue
// Two-entry FIFO of parser operations between front and back.
// ----------------------------------------------------------------------------
module fds16_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fds16_pkg::q_entry_t wdata_i,
  output logic                full_o,
  output logic                valid_o,
  input  logic                pop_i,
  output fds16_pkg::q_entry_t rdata_o
);

  fds16_pkg::q_entry_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/fds16_back.sv -----
// ----------------------------------------------------------------------------
// fds16_back
// Frame store: holds codes and payload bytes, loads the output register on
// an emit operation and drives the result stream.
// ----------------------------------------------------------------------------
module fds16_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  fds16_pkg::q_entry_t              q_entry_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fds16_pkg::OutDataW-1:0]   out_data_o
);

  logic [fds16_pkg::ByteW-1:0]    func_q, sub_q;
  logic [fds16_pkg::ByteW-1:0]    pay_q [fds16_pkg::PayLen];
  logic [fds16_pkg::OutDataW-1:0] frame, out_data_q;
  logic                           out_valid_q, out_free, is_emit;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_emit  = (q_entry_i.op == fds16_pkg::OP_EMIT);
  assign q_pop_o  = q_valid_i && (!is_emit || out_free);

  always_comb begin
    frame = '0;
    frame[fds16_pkg::ByteW-1:0]                  = func_q;
    frame[2*fds16_pkg::ByteW-1:fds16_pkg::ByteW] = sub_q;
    for (int i = 0; i < fds16_pkg::PayLen; i++) begin
      frame[(i+2)*fds16_pkg::ByteW +: fds16_pkg::ByteW] = pay_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      unique case (q_entry_i.op)
        fds16_pkg::OP_FUNC:    func_q                <= q_entry_i.data;
        fds16_pkg::OP_SUBFUNC: sub_q                 <= q_entry_i.data;
        fds16_pkg::OP_PAYLOAD: pay_q[q_entry_i.idx]  <= q_entry_i.data;
        fds16_pkg::OP_EMIT:    out_data_q            <= frame;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o && is_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/fds16_checker.sv -----
// ----------------------------------------------------------------------------
// fds16_checker
// Port-level checks for the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module fds16_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fds16_pkg::OutDataW-1:0] m_axis_tdata
);

  logic out_stall;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> m_axis_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid && s_axis_tready)
    else $error("outputs not quiet in reset");

  a_backpressure_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(out_stall))
    else $error("input stalled without a stalled result");

endmodule

bind frame_deframer_sum16 fds16_checker u_fds16_checker (.*);
